### src/worley_cell_noise_nearest_defines.svh
// Assertion macros used by the checker file.
`ifndef WORLEY_CELL_NOISE_NEAREST_DEFINES_SVH
`define WORLEY_CELL_NOISE_NEAREST_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define WCN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every clock edge, also while reset is held.
`define WCN_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/wcn_pkg.sv
//------------------------------------------------------------------------------
// wcn_pkg
// Shared types and constants of the Worley cellular noise block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package wcn_pkg;

    // Item kinds carried in the mode field.
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_E2D  = 2'd1;
    localparam logic [1:0] MODE_E3D  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam int DIST_W = 20;
    localparam logic [DIST_W-1:0] DIST_MAX = 20'hFFFFF;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CELL,
        ST_RD,
        ST_WAIT,
        ST_AXIS,
        ST_SQ,
        ST_ACC,
        ST_SQRT,
        ST_OUT
    } t_state;

endpackage

### src/wcn_ram.sv
//------------------------------------------------------------------------------
// wcn_ram
// Generic single-port-write, single-port-read RAM with registered read data.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module wcn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/wcn_sqrt.sv
//------------------------------------------------------------------------------
// wcn_sqrt
// Iterative integer square root, one result bit per cycle, floor.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module wcn_sqrt #(
    parameter int IN_W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [IN_W-1:0]   i_value,
    output logic              o_done,
    output logic [IN_W/2-1:0] o_root
);

    localparam int RW = IN_W / 2;
    localparam int CW = $clog2(RW + 1);

    logic [IN_W-1:0] r_rem, n_rem;
    logic [RW-1:0]   r_root, n_root;
    logic [IN_W-1:0] r_src, n_src;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [IN_W+1:0] w_trial;
    logic [IN_W+1:0] w_part;

    // Bring down two bits each step and try to subtract 4*root+1.
    always_comb begin
        w_part  = {r_rem, r_src[IN_W-1 -: 2]};
        w_trial = {r_root, 2'b01};
        n_rem   = r_rem;
        n_root  = r_root;
        n_src   = r_src;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_root = '0;
            n_src  = i_value;
            n_cnt  = CW'(RW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_src = {r_src[IN_W-3:0], 2'b00};
            if (w_part >= w_trial) begin
                n_rem  = IN_W'(w_part - w_trial);
                n_root = {r_root[RW-2:0], 1'b1};
            end else begin
                n_rem  = IN_W'(w_part);
                n_root = {r_root[RW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_root <= n_root;
        r_src  <= n_src;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### src/wcn_core.sv
//------------------------------------------------------------------------------
// wcn_core
// Sequencer: table clear and loads, chained hash lookups per neighbour cell,
// squared distances, running minimum and final square root.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module wcn_core #(
    parameter int TABLE_SIZE = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic [31:0]       i_x,
    input  logic [31:0]       i_y,
    input  logic [31:0]       i_z,
    input  logic [7:0]        i_tidx,
    input  logic [7:0]        i_tval,
    output logic              o_res_valid,
    output logic [19:0]       o_res,
    input  logic              i_res_taken
);

    localparam int AW   = $clog2(TABLE_SIZE);
    localparam int LIMV = 16 << FRAC_BITS;
    localparam int DW   = FRAC_BITS + 5;       // magnitude up to 16.0
    localparam int SQW  = 2 * DW;
    localparam int SUMW = SQW + 2;

    wcn_pkg::t_state r_st, n_st;

    logic [AW-1:0]   r_clr, n_clr;
    logic            r_3d, n_3d;
    logic signed [31:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic signed [32:0] r_tx, r_ty, r_tz, n_tx, n_ty, n_tz;
    logic [1:0]      r_i, r_j, r_k, n_i, n_j, n_k;
    logic [1:0]      r_ax, n_ax;      // axis being hashed, 0..2
    logic [2:0]      r_step, n_step;  // position in the lookup chain
    logic [7:0]      r_h, n_h;        // previous lookup result
    logic [DW-1:0]   r_d, n_d;
    logic [SUMW-1:0] r_sum, n_sum;
    logic [SUMW-1:0] r_best, n_best;
    logic            r_first, n_first;
    logic            r_ov, n_ov;
    logic [19:0]     r_res, n_res;
    logic            r_rv, n_rv;

    logic            w_we;
    logic [AW-1:0]   w_waddr, w_raddr;
    logic [7:0]      w_wdata, w_rdata;
    logic            w_sq_start, w_sq_done;
    logic [63:0]     w_sq_in;
    logic [31:0]     w_root;
    logic [SQW-1:0]  w_sq;

    wcn_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    wcn_sqrt #(.IN_W(64)) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_sq_start),
        .i_value(w_sq_in),
        .o_done (w_sq_done),
        .o_root (w_root)
    );

    // Truncate toward zero to a cell index.
    function automatic logic signed [32:0] cell_of(input logic signed [31:0] v);
        logic signed [32:0] m;
        m = v;
        if (v[31]) begin
            cell_of = -((-m) >>> FRAC_BITS);
        end else begin
            cell_of = m >>> FRAC_BITS;
        end
    endfunction

    // Clamped absolute axis difference between coordinate and feature point.
    function automatic logic [DW-1:0] axis_d(input logic signed [31:0] c,
                                             input logic signed [32:0] t,
                                             input logic [7:0] h);
        logic signed [63:0] p;
        logic signed [63:0] off;
        logic signed [63:0] d;
        p   = 64'(t) <<< FRAC_BITS;
        off = 64'(h) <<< (FRAC_BITS - 8);
        if (!t[32] && t != 0) p = p + off;
        else if (t[32]) p = p - off;
        d = 64'(c) - p;
        if (d < 0) d = -d;
        if (d > 64'(LIMV)) d = 64'(LIMV);
        axis_d = DW'(d);
    endfunction

    // Square of the current axis difference at full width.
    assign w_sq = r_d * r_d;

    // Index of the current lookup in the chain (base value plus key).
    logic [AW-1:0] w_key;
    always_comb begin
        logic [AW-1:0] seed;
        seed  = AW'(r_ax + 2'd1);
        w_key = seed;
        if (r_3d) begin
            unique case (r_step)
                3'd0: w_key = seed;
                3'd1: w_key = AW'(r_tz) + AW'(r_h);
                3'd2: w_key = AW'(r_ty) + AW'(r_h);
                default: w_key = AW'(r_tx) + AW'(r_h);
            endcase
        end else begin
            unique case (r_step)
                3'd0: w_key = seed;
                3'd1: w_key = AW'(r_ty) + AW'(r_h);
                default: w_key = AW'(r_tx) + AW'(r_h);
            endcase
        end
    end

    logic [2:0] w_last_step;
    assign w_last_step = r_3d ? 3'd3 : 3'd2;

    // Sequencer.
    always_comb begin
        logic [63:0] scaled;
        n_st = r_st; n_clr = r_clr; n_3d = r_3d;
        n_x = r_x; n_y = r_y; n_z = r_z;
        n_tx = r_tx; n_ty = r_ty; n_tz = r_tz;
        n_i = r_i; n_j = r_j; n_k = r_k;
        n_ax = r_ax; n_step = r_step; n_h = r_h;
        n_d = r_d; n_sum = r_sum;
        n_best = r_best; n_first = r_first; n_ov = r_ov;
        n_res = r_res; n_rv = r_rv;
        w_we = 1'b0; w_waddr = r_clr; w_wdata = 8'(r_clr);
        w_raddr = w_key;
        w_sq_start = 1'b0;
        scaled = '0;
        if (2 * FRAC_BITS <= 32) scaled = 64'(r_best) << (32 - 2 * FRAC_BITS);
        else scaled = 64'(r_best >> (2 * FRAC_BITS - 32));
        w_sq_in = scaled;
        o_ready = 1'b0;
        if (i_res_taken) n_rv = 1'b0;
        unique case (r_st)
            wcn_pkg::ST_CLEAR: begin
                w_we = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(TABLE_SIZE - 1)) n_st = wcn_pkg::ST_IDLE;
            end
            wcn_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_x = i_x; n_y = i_y; n_z = i_z;
                    n_3d = (i_mode == wcn_pkg::MODE_E3D);
                    unique case (i_mode)
                        wcn_pkg::MODE_LOAD: begin
                            w_we = 1'b1;
                            w_waddr = AW'(i_tidx);
                            w_wdata = i_tval;
                        end
                        wcn_pkg::MODE_E2D, wcn_pkg::MODE_E3D: begin
                            n_st = wcn_pkg::ST_CELL;
                            n_i = '0; n_j = '0; n_k = '0;
                            n_first = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            wcn_pkg::ST_CELL: begin
                n_tx = cell_of(r_x) + 33'(r_i) - 33'sd1;
                n_ty = cell_of(r_y) + 33'(r_j) - 33'sd1;
                n_tz = cell_of(r_z) + 33'(r_k) - 33'sd1;
                n_ax = '0; n_step = '0; n_sum = '0;
                n_st = wcn_pkg::ST_RD;
            end
            wcn_pkg::ST_RD: begin
                n_st = wcn_pkg::ST_WAIT;
            end
            wcn_pkg::ST_WAIT: begin
                n_h = w_rdata;
                if (r_step == w_last_step) begin
                    n_st = wcn_pkg::ST_AXIS;
                end else begin
                    n_step = r_step + 1'b1;
                    n_st = wcn_pkg::ST_RD;
                end
            end
            wcn_pkg::ST_AXIS: begin
                if (r_ax == 2'd0) begin
                    n_d = axis_d(r_x, r_tx, r_h);
                end else if (r_ax == 2'd1) begin
                    n_d = axis_d(r_y, r_ty, r_h);
                end else begin
                    n_d = axis_d(r_z, r_tz, r_h);
                end
                n_st = wcn_pkg::ST_SQ;
            end
            wcn_pkg::ST_SQ: begin
                n_sum = r_sum + SUMW'(w_sq);
                if ((r_3d && r_ax == 2'd2) || (!r_3d && r_ax == 2'd1)) begin
                    n_st = wcn_pkg::ST_ACC;
                end else begin
                    n_ax = r_ax + 1'b1;
                    n_step = '0;
                    n_st = wcn_pkg::ST_RD;
                end
            end
            wcn_pkg::ST_ACC: begin
                if (r_first || r_sum < r_best) n_best = r_sum;
                n_first = 1'b0;
                n_st = wcn_pkg::ST_CELL;
                if (r_3d && r_k != 2'd2) begin
                    n_k = r_k + 1'b1;
                end else begin
                    n_k = '0;
                    if (r_j != 2'd2) begin
                        n_j = r_j + 1'b1;
                    end else begin
                        n_j = '0;
                        if (r_i != 2'd2) begin
                            n_i = r_i + 1'b1;
                        end else begin
                            n_st = wcn_pkg::ST_SQRT;
                            w_sq_start = 1'b0;
                        end
                    end
                end
                if (n_st == wcn_pkg::ST_SQRT) begin
                    n_ov = 1'b0;
                end
            end
            wcn_pkg::ST_SQRT: begin
                if (!r_ov) begin
                    w_sq_start = 1'b1;
                    n_ov = 1'b1;
                end else if (w_sq_done) begin
                    n_st = wcn_pkg::ST_OUT;
                end
            end
            // The root stays in the square root unit until the output register is free.
            wcn_pkg::ST_OUT: begin
                if (!r_rv || i_res_taken) begin
                    n_res = (w_root > 32'(wcn_pkg::DIST_MAX)) ? wcn_pkg::DIST_MAX
                                                              : w_root[19:0];
                    n_rv = 1'b1;
                    n_st = wcn_pkg::ST_IDLE;
                end
            end
            default: n_st = wcn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= wcn_pkg::ST_CLEAR;
            r_clr <= '0;
            r_rv  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_clr <= n_clr;
            r_rv  <= n_rv;
            r_ov  <= n_ov;
        end
        r_3d <= n_3d; r_x <= n_x; r_y <= n_y; r_z <= n_z;
        r_tx <= n_tx; r_ty <= n_ty; r_tz <= n_tz;
        r_i <= n_i; r_j <= n_j; r_k <= n_k;
        r_ax <= n_ax; r_step <= n_step; r_h <= n_h;
        r_d <= n_d; r_sum <= n_sum;
        r_best <= n_best; r_first <= n_first; r_res <= n_res;
    end

    assign o_res_valid = r_rv;
    assign o_res       = r_res;

endmodule

### src/worley_cell_noise_nearest.sv
//------------------------------------------------------------------------------
// worley_cell_noise_nearest
// Worley cellular noise, nearest feature distance in 2D or 3D.
//------------------------------------------------------------------------------
// Channel | Dir | tdata fields (lowest bit first)                  | tuser
// s_axis  | in  | coord_x[31:0], coord_y, coord_z, table_index,    | mode[1:0]
//         |     | table_value (112 bits)                            |
// m_axis  | out | distance[19:0], zero fill to 24 bits              | -
//
// A load item is written to the table on acceptance. An evaluate item walks 9 or 27
// cells; each cell runs 2 or 3 chains of 3 or 4 dependent table reads (each through
// the RD and WAIT states at the table memory port) plus the AXIS and SQ states per
// axis and the CELL and ACC states per cell, then the square root and the OUT state.
// After reset the table is cleared to identity before the first item is accepted.
// A finished result waits in the output register; a new item is accepted then.
`timescale 1ns / 1ps

module worley_cell_noise_nearest #(
    parameter int TABLE_SIZE = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,  // coord_x, coord_y, coord_z, table_index, table_value
    input  logic [1:0]   s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata   // distance, zero fill
);

    logic [19:0] w_res;

    wcn_core #(.TABLE_SIZE(TABLE_SIZE), .FRAC_BITS(FRAC_BITS)) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_mode     (s_axis_tuser),
        .i_x        (s_axis_tdata[31:0]),
        .i_y        (s_axis_tdata[63:32]),
        .i_z        (s_axis_tdata[95:64]),
        .i_tidx     (s_axis_tdata[103:96]),
        .i_tval     (s_axis_tdata[111:104]),
        .o_res_valid(m_axis_tvalid),
        .o_res      (w_res),
        .i_res_taken(m_axis_tvalid && m_axis_tready)
    );

    assign m_axis_tdata = {4'b0000, w_res};

endmodule

### src/wcn_checker.sv
//------------------------------------------------------------------------------
// wcn_checker
// Port-level checks on the Worley noise block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "worley_cell_noise_nearest_defines.svh"

module wcn_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [1:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [23:0]  m_axis_tdata
);

    logic w_load_in;
    logic w_out_stall;

    // A load item accepted while no result is shown, and a stalled result.
    assign w_load_in = s_axis_tvalid && s_axis_tready && !m_axis_tvalid
                    && (s_axis_tuser == wcn_pkg::MODE_LOAD);
    assign w_out_stall = m_axis_tvalid && !m_axis_tready;

    // No result is shown straight after reset.
    `WCN_ASSERT_NR(a_rst_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid, "result after reset")
    // A load item never produces a result in the next cycle.
    `WCN_ASSERT(a_load_quiet, i_clk, i_rst_n, w_load_in |=> !m_axis_tvalid, "load gave result")
    // The fill bits above the distance stay zero.
    `WCN_ASSERT(a_fill, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[23:20] == 4'd0, "fill bits set")
    // A stalled result holds its value.
    `WCN_ASSERT(a_hold, i_clk, i_rst_n, w_out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped")

endmodule

bind worley_cell_noise_nearest wcn_checker u_wcn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

### tb/sv/worley_cell_noise_nearest_tb.sv
//------------------------------------------------------------------------------
// worley_cell_noise_nearest_tb
// Self-checking bench for the Worley F1 block. Table loads and 2D/3D
// evaluate items are streamed in. A local model of the permutation table and
// of the distance search predicts each result. The output is checked in order.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module worley_cell_noise_nearest_tb;

    localparam int N_RANDOM   = 1150;
    localparam int WDOG_LIMIT = 20000;
    localparam int HOLD_LEN   = 3000;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] x, y, z;
        logic [7:0]  idx, val;
        bit          typed;
        logic [19:0] exp_dist;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;   // coord_x, coord_y, coord_z, table_index, table_value
    logic [1:0]   s_axis_tuser;   // mode
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [23:0]  m_axis_tdata;   // distance, zero fill

    logic [7:0]   perm_shadow [256];
    logic [19:0]  dist_q [$];
    t_row         rows [$];
    int           n_err, n_load, n_2d, n_3d, n_seen, wdog;
    bit           no_idle, hold_req;

    worley_cell_noise_nearest uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] perm_at(logic [31:0] i);
        return perm_shadow[i[7:0]];
    endfunction

    function automatic longint cell_of(longint v);
        if (v >= 0) return v >>> 16;
        return -((-v) >>> 16);
    endfunction

    // Feature coordinate: cell plus the hashed offset away from zero.
    function automatic longint feature_pos(longint t, logic [7:0] h);
        longint p;
        p = t * 65536;
        if (t > 0) p = p + longint'(h) * 256;
        else if (t < 0) p = p - longint'(h) * 256;
        return p;
    endfunction

    function automatic longint unsigned axis_sq(longint c, longint p);
        longint d;
        d = c - p;
        if (d < 0) d = -d;
        if (d > 64'sd1048576) d = 64'sd1048576;
        return longint'(d) * longint'(d);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Least distance over the 3x3 or 3x3x3 neighborhood, in Q4.16.
    function automatic logic [19:0] nearest_distance(logic [1:0] mode,
            logic [31:0] xr, logic [31:0] yr, logic [31:0] zr);
        longint x, y, z, cx, cy, cz, tx, ty, tz;
        longint unsigned best, s, r;
        logic [31:0] ux, uy, uz;
        logic [7:0] hx, hy, hz;
        int kmax;
        x = longint'($signed(xr));
        y = longint'($signed(yr));
        z = longint'($signed(zr));
        cx = cell_of(x);
        cy = cell_of(y);
        cz = cell_of(z);
        kmax = (mode == wcn_pkg::MODE_E3D) ? 3 : 1;
        best = '1;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < kmax; k++) begin
                    tx = cx + i - 1;
                    ty = cy + j - 1;
                    tz = cz + k - 1;
                    ux = tx[31:0];
                    uy = ty[31:0];
                    uz = tz[31:0];
                    if (mode == wcn_pkg::MODE_E2D) begin
                        hx = perm_at(ux + perm_at(uy + perm_at(1)));
                        hy = perm_at(ux + perm_at(uy + perm_at(2)));
                        s = axis_sq(x, feature_pos(tx, hx))
                          + axis_sq(y, feature_pos(ty, hy));
                    end else begin
                        hx = perm_at(ux + perm_at(uy + perm_at(uz + perm_at(1))));
                        hy = perm_at(ux + perm_at(uy + perm_at(uz + perm_at(2))));
                        hz = perm_at(ux + perm_at(uy + perm_at(uz + perm_at(3))));
                        s = axis_sq(x, feature_pos(tx, hx))
                          + axis_sq(y, feature_pos(ty, hy))
                          + axis_sq(z, feature_pos(tz, hz));
                    end
                    if (s < best) best = s;
                end
            end
        end
        r = floor_sqrt(best);
        if (r > 64'hFFFFF) r = 64'hFFFFF;
        return r[19:0];
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(3) == 0) return $urandom;
        return 32'($urandom_range(1048576)) - 32'd524288;
    endfunction

    function automatic void add_row(logic [1:0] m, logic [31:0] x, logic [31:0] y,
            logic [31:0] z, logic [7:0] idx, logic [7:0] val, bit typed, logic [19:0] d);
        t_row r;
        r.mode = m; r.x = x; r.y = y; r.z = z;
        r.idx = idx; r.val = val; r.typed = typed; r.exp_dist = d;
        rows.push_back(r);
    endfunction

    // Offer one item, wait for its acceptance, then update the model.
    task automatic send_item(t_row r);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.val, r.idx, r.z, r.y, r.x};
        s_axis_tuser  <= r.mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        case (r.mode)
            wcn_pkg::MODE_LOAD: begin
                perm_shadow[r.idx] = r.val;
                n_load++;
            end
            wcn_pkg::MODE_E2D, wcn_pkg::MODE_E3D: begin
                dist_q.push_back(r.typed ? r.exp_dist
                                         : nearest_distance(r.mode, r.x, r.y, r.z));
                if (r.mode == wcn_pkg::MODE_E2D) n_2d++;
                else n_3d++;
            end
            default: ;
        endcase
        if (!no_idle && $urandom_range(99) < 25) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= no_idle || ($urandom_range(99) >= 25);
        end
    end

    // Output check against the oldest expected distance.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_seen++;
            if (dist_q.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, m_axis_tdata);
                n_err++;
            end else begin
                if (m_axis_tdata[19:0] !== dist_q[0]) begin
                    $display("%0t: distance mismatch, expected %h actual %h",
                             $time, dist_q[0], m_axis_tdata[19:0]);
                    n_err++;
                end
                void'(dist_q.pop_front());
            end
        end
    end

    // Watchdog on cycles with no item moving on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
            if (wdog == WDOG_LIMIT) begin
                $display("%0t: no progress, %0d results pending", $time, dist_q.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        t_row r;
        n_err = 0; n_load = 0; n_2d = 0; n_3d = 0; n_seen = 0; wdog = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = wcn_pkg::MODE_LOAD;
        for (int i = 0; i < 256; i++) perm_shadow[i] = 8'(i);

        // Directed rows: origin and half-cell points have obvious answers.
        add_row(wcn_pkg::MODE_E2D, 32'h0, 32'h0, 32'h0, 8'h0, 8'h0, 1'b1, 20'h00000);
        add_row(wcn_pkg::MODE_E3D, 32'h0, 32'h0, 32'h0, 8'h0, 8'h0, 1'b1, 20'h00000);
        add_row(wcn_pkg::MODE_E2D, 32'hFFFF8000, 32'h0, 32'h0, 8'h0, 8'h0,
                1'b1, 20'h08000);
        add_row(wcn_pkg::MODE_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                8'hFF, 8'hFF, 1'b0, 20'h0);
        add_row(wcn_pkg::MODE_LOAD, 32'hFFFFFFFF, 32'h0, 32'h0, 8'hFF, 8'h00,
                1'b0, 20'h0);
        add_row(wcn_pkg::MODE_LOAD, 32'h0, 32'h0, 32'h0, 8'h00, 8'hFF, 1'b0, 20'h0);
        add_row(wcn_pkg::MODE_LOAD, 32'h0, 32'h0, 32'h0, 8'h01, 8'h80, 1'b0, 20'h0);
        add_row(wcn_pkg::MODE_E2D, 32'h7FFFFFFF, 32'h80000000, 32'h0, 8'h0, 8'h0,
                1'b0, 20'h0);
        add_row(wcn_pkg::MODE_E2D, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF,
                8'h0, 8'h0, 1'b0, 20'h0);
        add_row(wcn_pkg::MODE_E3D, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                8'h0, 8'h0, 1'b0, 20'h0);
        add_row(wcn_pkg::MODE_E3D, 32'h80000000, 32'h80000000, 32'h80000000,
                8'h0, 8'h0, 1'b0, 20'h0);
        add_row(wcn_pkg::MODE_E2D, 32'h0000FFFF, 32'hFFFF0001, 32'h0, 8'h0, 8'h0,
                1'b0, 20'h0);
        add_row(wcn_pkg::MODE_E3D, 32'h00018000, 32'hFFFE8000, 32'h00008000,
                8'h0, 8'h0, 1'b0, 20'h0);
        add_row(wcn_pkg::MODE_E2D, 32'h00010000, 32'hFFFF0000, 32'h0, 8'h0, 8'h0,
                1'b0, 20'h0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) send_item(rows[i]);

        for (int n = 0; n < N_RANDOM; n++) begin
            int pick;
            // A quiet stretch with no idling on either side.
            no_idle = (n >= 800 && n < 950);
            if (n == 300) hold_req = 1'b1;
            if (n == 600) begin
                s_axis_tvalid <= 1'b0;
                while (dist_q.size() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(99);
            r.mode  = (pick < 35) ? wcn_pkg::MODE_LOAD :
                      (pick < 85) ? wcn_pkg::MODE_E2D :
                      (pick < 97) ? wcn_pkg::MODE_E3D : wcn_pkg::MODE_NONE;
            r.x     = rand_coord();
            r.y     = rand_coord();
            r.z     = rand_coord();
            r.idx   = 8'($urandom);
            r.val   = 8'($urandom);
            r.typed = 1'b0;
            r.exp_dist = '0;
            send_item(r);
        end
        s_axis_tvalid <= 1'b0;

        while (dist_q.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);

        $display("covered %0d table loads, %0d 2D and %0d 3D evaluations, %0d results",
                 n_load, n_2d, n_3d, n_seen);
        $display("including a long output hold-off and a drain pause; %0d mismatches", n_err);
        if (n_err == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
